FILE: src/tvsd_pkg.sv
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared types, codes and tag lookup for the tagged value stream decoder.
// ----------------------------------------------------------------------------
package tvsd_pkg;

  // Depth of the result queue that separates the decoder from the output.
  localparam int unsigned TVSD_RES_DEPTH = 4;

  // Number of bytes in a raw date or number value.
  localparam logic [3:0] TVSD_NUM_BYTES = 4'd8;

  // Varint bits at or above this shift are dropped.
  localparam logic [5:0] TVSD_VARINT_BITS = 6'd32;
  localparam logic [5:0] TVSD_VARINT_STEP = 6'd7;

  // Tag bytes.
  localparam logic [7:0] CH_PAD      = 8'h00;
  localparam logic [7:0] CH_UNDEF    = 8'h5F;  // '_'
  localparam logic [7:0] CH_NULL     = 8'h30;  // '0'
  localparam logic [7:0] CH_TRUE     = 8'h54;  // 'T'
  localparam logic [7:0] CH_FALSE    = 8'h46;  // 'F'
  localparam logic [7:0] CH_STRING   = 8'h53;  // 'S'
  localparam logic [7:0] CH_INT32    = 8'h49;  // 'I'
  localparam logic [7:0] CH_UINT32   = 8'h55;  // 'U'
  localparam logic [7:0] CH_DATE     = 8'h44;  // 'D'
  localparam logic [7:0] CH_NUMBER   = 8'h4E;  // 'N'
  localparam logic [7:0] CH_BLOB     = 8'h62;  // 'b'
  localparam logic [7:0] CH_FILE     = 8'h66;  // 'f'
  localparam logic [7:0] CH_FILELIST = 8'h6C;  // 'l'
  localparam logic [7:0] CH_IMAGE    = 8'h23;  // '#'
  localparam logic [7:0] CH_ARRAY    = 8'h5B;  // '['
  localparam logic [7:0] CH_OBJECT   = 8'h7B;  // '{'
  localparam logic [7:0] CH_SPARSE   = 8'h40;  // '@'

  typedef enum logic [3:0] {
    TAG_UNDEF    = 4'd0,
    TAG_NULL     = 4'd1,
    TAG_TRUE     = 4'd2,
    TAG_FALSE    = 4'd3,
    TAG_STRING   = 4'd4,
    TAG_INT32    = 4'd5,
    TAG_UINT32   = 4'd6,
    TAG_DATE     = 4'd7,
    TAG_NUMBER   = 4'd8,
    TAG_BLOB     = 4'd9,
    TAG_FILE     = 4'd10,
    TAG_FILELIST = 4'd11,
    TAG_IMAGE    = 4'd12,
    TAG_ARRAY    = 4'd13,
    TAG_OBJECT   = 4'd14,
    TAG_SPARSE   = 4'd15
  } tvsd_tag_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_BARE    = 2'd2,
    KIND_VERDICT = 2'd3
  } tvsd_kind_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_BAD_TAG = 3'd1,
    ERR_TRUNC   = 3'd2,
    ERR_COUNT   = 3'd3,
    ERR_DEPTH   = 3'd4
  } tvsd_err_e;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_VARINT  = 2'd1,
    PH_NUMBER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } tvsd_phase_e;

  typedef struct packed {
    tvsd_phase_e phase;
    tvsd_tag_e   tag;
    logic [1:0]  hdr_cnt;
    logic [31:0] vacc;
    logic [5:0]  vshift;
    logic [63:0] nacc;
    logic [3:0]  nseen;
    logic [31:0] pay_rem;
    logic [31:0] list_rem;
    logic [31:0] first_hdr;
    logic [31:0] depth;
    logic        failed;
  } tvsd_state_t;

  localparam tvsd_state_t TVSD_STATE_RST = '{
    phase:     PH_TAG,
    tag:       TAG_UNDEF,
    hdr_cnt:   2'd0,
    vacc:      32'd0,
    vshift:    6'd0,
    nacc:      64'd0,
    nseen:     4'd0,
    pay_rem:   32'd0,
    list_rem:  32'd0,
    first_hdr: 32'd0,
    depth:     32'd0,
    failed:    1'b0
  };

  typedef struct packed {
    tvsd_kind_e  kind;
    tvsd_tag_e   tag;
    logic [1:0]  fidx;
    logic [63:0] fval;
    logic [7:0]  pbyte;
    logic        done;
    tvsd_err_e   err;
    logic        last;
  } tvsd_result_t;

  typedef struct packed {
    logic      pad;
    logic      ok;
    tvsd_tag_e code;
  } tvsd_tagdec_t;

  function automatic tvsd_tagdec_t tag_lookup(input logic [7:0] b);
    tvsd_tagdec_t r;
    r.pad  = 1'b0;
    r.ok   = 1'b1;
    r.code = TAG_UNDEF;
    case (b)
      CH_PAD:      begin r.pad = 1'b1; r.ok = 1'b0; end
      CH_UNDEF:    r.code = TAG_UNDEF;
      CH_NULL:     r.code = TAG_NULL;
      CH_TRUE:     r.code = TAG_TRUE;
      CH_FALSE:    r.code = TAG_FALSE;
      CH_STRING:   r.code = TAG_STRING;
      CH_INT32:    r.code = TAG_INT32;
      CH_UINT32:   r.code = TAG_UINT32;
      CH_DATE:     r.code = TAG_DATE;
      CH_NUMBER:   r.code = TAG_NUMBER;
      CH_BLOB:     r.code = TAG_BLOB;
      CH_FILE:     r.code = TAG_FILE;
      CH_FILELIST: r.code = TAG_FILELIST;
      CH_IMAGE:    r.code = TAG_IMAGE;
      CH_ARRAY:    r.code = TAG_ARRAY;
      CH_OBJECT:   r.code = TAG_OBJECT;
      CH_SPARSE:   r.code = TAG_SPARSE;
      default:     r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tvsd_result_t mk_res(input tvsd_kind_e kind, input tvsd_tag_e tag,
                                          input logic [1:0] fidx, input logic [63:0] fval,
                                          input logic [7:0] pbyte, input logic done);
    tvsd_result_t r;
    r.kind  = kind;
    r.tag   = tag;
    r.fidx  = fidx;
    r.fval  = fval;
    r.pbyte = pbyte;
    r.done  = done;
    r.err   = ERR_OK;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

FILE: src/tvsd_decode.sv
// ----------------------------------------------------------------------------
// tvsd_decode
// Next-state and result logic for one accepted byte of the value stream.
// ----------------------------------------------------------------------------
module tvsd_decode import tvsd_pkg::*; (
  input  tvsd_state_t  state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  output tvsd_state_t  state_o,
  output tvsd_result_t res0_o,
  output tvsd_result_t res1_o,
  output logic [1:0]   res_cnt_o
);

  tvsd_state_t  nx;
  tvsd_result_t tok;
  tvsd_result_t verdict;
  tvsd_tagdec_t td;
  logic         tok_v;
  logic         fail_v;
  tvsd_err_e    fail_err;
  logic         end_v;
  tvsd_err_e    end_err;
  logic         comp_req;
  logic [32:0]  comp_need;
  logic [1:0]   comp_fidx;
  logic [38:0]  vsh;
  logic [31:0]  v;
  logic [31:0]  zz;
  logic [63:0]  nacc_new;
  logic [3:0]   nseen_new;
  logic [31:0]  prem_new;
  logic [31:0]  lrem_new;
  logic [32:0]  depth_calc;

  function automatic tvsd_state_t push_value(input tvsd_state_t s);
    tvsd_state_t r;
    r = s;
    if (r.depth != '1) begin
      r.depth = r.depth + 32'd1;
    end
    r.phase = PH_TAG;
    return r;
  endfunction

  function automatic tvsd_state_t start_varint(input tvsd_state_t s);
    tvsd_state_t r;
    r        = s;
    r.vacc   = '0;
    r.vshift = '0;
    r.phase  = PH_VARINT;
    return r;
  endfunction

  function automatic tvsd_state_t start_payload(input tvsd_state_t s, input logic [31:0] len);
    tvsd_state_t r;
    r         = s;
    r.pay_rem = len;
    r.phase   = PH_PAYLOAD;
    return r;
  endfunction

  always_comb begin
    nx        = state_i;
    tok       = '0;
    tok_v     = 1'b0;
    fail_v    = 1'b0;
    fail_err  = ERR_OK;
    end_v     = 1'b0;
    end_err   = ERR_OK;
    comp_req  = 1'b0;
    comp_need = '0;
    comp_fidx = '0;
    depth_calc = '0;
    td        = tag_lookup(data_byte_i);

    // Varint accumulation: bits past the 32-bit window are dropped.
    vsh = 39'(data_byte_i[6:0]) << state_i.vshift;
    v   = (state_i.vshift < TVSD_VARINT_BITS) ? (state_i.vacc | vsh[31:0]) : state_i.vacc;
    zz  = v[0] ? ~(v >> 1) : (v >> 1);

    nacc_new  = state_i.nacc | (64'(data_byte_i) << {state_i.nseen[2:0], 3'b000});
    nseen_new = state_i.nseen + 4'd1;
    prem_new  = state_i.pay_rem - 32'd1;
    lrem_new  = state_i.list_rem - 32'd1;

    if (!state_i.failed) begin
      case (state_i.phase)
        PH_VARINT: begin
          if (state_i.vshift < TVSD_VARINT_BITS) begin
            nx.vacc   = v;
            nx.vshift = state_i.vshift + TVSD_VARINT_STEP;
          end
          if (!data_byte_i[7]) begin
            case (state_i.tag)
              TAG_INT32: begin
                tok_v = 1'b1;
                tok   = mk_res(KIND_HEADER, state_i.tag, 2'd0, {{32{zz[31]}}, zz}, 8'd0, 1'b1);
                nx    = push_value(nx);
              end
              TAG_UINT32: begin
                tok_v = 1'b1;
                tok   = mk_res(KIND_HEADER, state_i.tag, 2'd0, 64'(v), 8'd0, 1'b1);
                nx    = push_value(nx);
              end
              TAG_STRING, TAG_BLOB, TAG_FILE: begin
                tok_v = 1'b1;
                tok   = mk_res(KIND_HEADER, state_i.tag, 2'd0, 64'(v), 8'd0, v == '0);
                nx    = (v == '0) ? push_value(nx) : start_payload(nx, v);
              end
              TAG_FILELIST: begin
                tok_v = 1'b1;
                if (state_i.hdr_cnt == 2'd0) begin
                  tok = mk_res(KIND_HEADER, state_i.tag, 2'd0, 64'(v), 8'd0, v == '0);
                  if (v == '0) begin
                    nx = push_value(nx);
                  end else begin
                    nx.list_rem = v;
                    nx.hdr_cnt  = 2'd1;
                    nx          = start_varint(nx);
                  end
                end else begin
                  nx.list_rem = lrem_new;
                  if (v == '0) begin
                    tok = mk_res(KIND_HEADER, state_i.tag, 2'd1, 64'd0, 8'd0, lrem_new == '0);
                    nx  = (lrem_new == '0) ? push_value(nx) : start_varint(nx);
                  end else begin
                    tok = mk_res(KIND_HEADER, state_i.tag, 2'd1, 64'(v), 8'd0, 1'b0);
                    nx  = start_payload(nx, v);
                  end
                end
              end
              TAG_IMAGE: begin
                tok_v = 1'b1;
                if (state_i.hdr_cnt < 2'd2) begin
                  tok        = mk_res(KIND_HEADER, state_i.tag, state_i.hdr_cnt, 64'(v),
                                      8'd0, 1'b0);
                  nx.hdr_cnt = state_i.hdr_cnt + 2'd1;
                  nx         = start_varint(nx);
                end else begin
                  tok = mk_res(KIND_HEADER, state_i.tag, 2'd2, 64'(v), 8'd0, v == '0);
                  nx  = (v == '0) ? push_value(nx) : start_payload(nx, v);
                end
              end
              TAG_ARRAY: begin
                comp_req  = 1'b1;
                comp_need = 33'(v);
              end
              TAG_OBJECT: begin
                comp_req  = 1'b1;
                comp_need = {v, 1'b0};
              end
              default: begin
                // Sparse array: property count first, then length.
                if (state_i.hdr_cnt == 2'd0) begin
                  tok_v        = 1'b1;
                  tok          = mk_res(KIND_HEADER, state_i.tag, 2'd0, 64'(v), 8'd0, 1'b0);
                  nx.first_hdr = v;
                  nx.hdr_cnt   = 2'd1;
                  nx           = start_varint(nx);
                end else begin
                  comp_req  = 1'b1;
                  comp_need = {state_i.first_hdr, 1'b0};
                  comp_fidx = 2'd1;
                end
              end
            endcase
          end
        end
        PH_NUMBER: begin
          nx.nacc  = nacc_new;
          nx.nseen = nseen_new;
          if (nseen_new >= TVSD_NUM_BYTES) begin
            tok_v = 1'b1;
            tok   = mk_res(KIND_HEADER, state_i.tag, 2'd0, nacc_new, 8'd0, 1'b1);
            nx    = push_value(nx);
          end
        end
        PH_PAYLOAD: begin
          tok_v      = 1'b1;
          nx.pay_rem = prem_new;
          if (prem_new == '0) begin
            if ((state_i.tag == TAG_FILELIST) && (state_i.list_rem != '0)) begin
              tok = mk_res(KIND_PAYLOAD, state_i.tag, 2'd0, 64'd0, data_byte_i, 1'b0);
              nx  = start_varint(nx);
            end else begin
              tok = mk_res(KIND_PAYLOAD, state_i.tag, 2'd0, 64'd0, data_byte_i, 1'b1);
              nx  = push_value(nx);
            end
          end else begin
            tok = mk_res(KIND_PAYLOAD, state_i.tag, 2'd0, 64'd0, data_byte_i, 1'b0);
          end
        end
        default: begin
          if (td.ok) begin
            nx.tag     = td.code;
            nx.hdr_cnt = 2'd0;
            if (td.code < TAG_STRING) begin
              tok_v = 1'b1;
              tok   = mk_res(KIND_BARE, td.code, 2'd0, 64'd0, 8'd0, 1'b1);
              nx    = push_value(nx);
            end else if ((td.code == TAG_DATE) || (td.code == TAG_NUMBER)) begin
              nx.nacc  = '0;
              nx.nseen = '0;
              nx.phase = PH_NUMBER;
            end else begin
              nx = start_varint(nx);
            end
          end else if (!td.pad) begin
            fail_v   = 1'b1;
            fail_err = ERR_BAD_TAG;
          end
        end
      endcase

      // Array, object and sparse array headers take values off the stack.
      if (comp_req) begin
        if (comp_need > {1'b0, state_i.depth}) begin
          fail_v   = 1'b1;
          fail_err = ERR_COUNT;
        end else begin
          tok_v      = 1'b1;
          tok        = mk_res(KIND_HEADER, state_i.tag, comp_fidx, 64'(v), 8'd0, 1'b1);
          depth_calc = {1'b0, state_i.depth} - comp_need + 33'd1;
          nx.depth   = depth_calc[31:0];
          nx.phase   = PH_TAG;
        end
      end

      if (fail_v) begin
        nx.failed = 1'b1;
      end

      end_v = last_byte_i && !fail_v;
      if (nx.phase != PH_TAG) begin
        end_err = ERR_TRUNC;
      end else if (nx.depth == 32'd1) begin
        end_err = ERR_OK;
      end else begin
        end_err = ERR_DEPTH;
      end
    end

    if (last_byte_i) begin
      nx = TVSD_STATE_RST;
    end
  end

  always_comb begin
    verdict      = mk_res(KIND_VERDICT, TAG_UNDEF, 2'd0, 64'd0, 8'd0, 1'b0);
    verdict.err  = fail_v ? fail_err : end_err;
    res0_o       = tok_v ? tok : verdict;
    res1_o       = verdict;
    res_cnt_o    = 2'(tok_v) + 2'(fail_v | end_v);
    if (res_cnt_o == 2'd2) begin
      res1_o.last = 1'b1;
    end else begin
      res0_o.last = 1'b1;
    end
  end

  assign state_o = nx;

endmodule

FILE: src/tvsd_resq.sv
// ----------------------------------------------------------------------------
// tvsd_resq
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module tvsd_resq import tvsd_pkg::*; #(
  parameter int unsigned Depth = TVSD_RES_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_cnt_i,
  input  tvsd_result_t               push0_i,
  input  tvsd_result_t               push1_i,
  input  logic                       pop_i,
  output tvsd_result_t               head_o,
  output logic                       valid_o,
  output logic                       room2_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tvsd_result_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nx = ptr_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_cnt_i == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_cnt_i == 2'd2) begin
      wr_d = ptr_inc(wr_nx);
    end
    if (pop_i) begin
      rd_d = ptr_inc(rd_q);
    end
    cnt_d = cnt_q + CntW'(push_cnt_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_nx] <= push1_i;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= CntW'(Depth - 2));
  assign count_o = cnt_q;

endmodule

FILE: src/tagged_value_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tagged_value_stream_decoder_top
// Byte-stream decoder for tagged values with a result queue on the output.
// ----------------------------------------------------------------------------
// The first result of a byte is offered in the cycle after the byte is
//   accepted, when the result queue is empty.
// Throughput: one byte per cycle while each byte yields at most one result
//   and the output is not stalled; the queue of FifoDepth entries absorbs
//   second results. A byte is taken whenever the queue has two free slots.
// Reset: rst_ni clears the parse state and empties the queue at once.
// ----------------------------------------------------------------------------
module tagged_value_stream_decoder_top import tvsd_pkg::*; #(
  parameter int unsigned FifoDepth = TVSD_RES_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [3:0]  tag_code_o,
  output logic [1:0]  field_index_o,
  output logic [63:0] field_value_o,
  output logic [7:0]  payload_byte_o,
  output logic        token_done_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  // The parse state lives in one register. Every accepted byte is decoded in
  // a single combinational pass from that state; the next state is written
  // back and the results of the byte are written into the queue together.
  tvsd_state_t  state_q, state_d;
  tvsd_result_t res0, res1, head;
  logic [1:0]   res_cnt;
  logic [1:0]   push_cnt;
  logic         in_acc;
  logic         out_acc;
  logic         room2;
  logic [$clog2(FifoDepth+1)-1:0] q_count;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  tvsd_decode u_decode (
    .state_i     (state_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .state_o     (state_d),
    .res0_o      (res0),
    .res1_o      (res1),
    .res_cnt_o   (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TVSD_STATE_RST;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // A byte can give up to two results, so a byte is only taken when two
  // entries are free. The queue output doubles as the output register.
  assign push_cnt   = in_acc ? res_cnt : 2'd0;
  assign in_ready_o = room2;

  tvsd_resq #(
    .Depth (FifoDepth)
  ) u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (out_acc),
    .head_o     (head),
    .valid_o    (out_valid_o),
    .room2_o    (room2),
    .count_o    (q_count)
  );

  assign out_kind_o     = head.kind;
  assign tag_code_o     = head.tag;
  assign field_index_o  = head.fidx;
  assign field_value_o  = head.fval;
  assign payload_byte_o = head.pbyte;
  assign token_done_o   = head.done;
  assign error_code_o   = head.err;
  assign last_of_run_o  = head.last;

  // A byte that ends the buffer always leaves the parser in its reset state.
  a_last_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> state_q == TVSD_STATE_RST)
    else $error("parse state not cleared after the last byte");

  // Once a failure is recorded, bytes add nothing to the queue.
  a_failed_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && state_q.failed |=> q_count <= $past(q_count))
    else $error("result produced while in the failed state");

  // A verdict is always the last result of its byte.
  a_verdict_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_VERDICT) |-> last_of_run_o)
    else $error("verdict not marked as last of run");

  // The queue never holds more entries than it has.
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> q_count <= ($clog2(FifoDepth+1))'(FifoDepth))
    else $error("result queue overflow");

endmodule
